### hdl/cpts_pkg.sv
// Shared constants, codes and record types of the CAN periodic transmit scheduler.
package cpts_pkg;

  // Table geometry. SLOT_W is the width of the slot field on the input channel.
  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int MAX_RES = 16;
  localparam int RES_W   = $clog2(MAX_RES + 1);

  // Input item kinds.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_KEY   = 2'd1;
  localparam logic [1:0] FUNC_SEND  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  // Transmission causes.
  localparam logic [1:0] CAUSE_TIMER = 2'd0;
  localparam logic [1:0] CAUSE_KEY   = 2'd1;
  localparam logic [1:0] CAUSE_SEND  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BUS_CONNECTED = 2'd0;
  localparam logic [1:0] CFG_SLOT_COUNT    = 2'd1;
  localparam logic [1:0] CFG_CLIENT_ID     = 2'd2;

  typedef struct packed {
    logic [28:0] id;
    logic [3:0]  len;
    logic [3:0]  chan;
    logic [63:0] data;
    logic [7:0]  key;
  } frame_rec_t;

  typedef struct packed {
    logic [15:0] period;
    logic [15:0] cdown;
  } timer_rec_t;

  typedef struct packed {
    logic ext;
    logic rtr;
    logic timer_en;
    logic key_en;
  } slot_flags_t;

  // Control of the slot store: write enables, write and read addresses.
  typedef struct packed {
    logic              fr_we;
    logic              tm_we;
    logic [SLOT_W-1:0] wr_slot;
    logic [SLOT_W-1:0] rd_slot;
  } mem_ctl_t;

endpackage

### hdl/cpts_slot_store.sv
// Slot table storage: frame memory, timer memory and resettable slot flags.
module cpts_slot_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpts_pkg::mem_ctl_t    ctl,
  input  cpts_pkg::frame_rec_t  wr_frame,
  input  cpts_pkg::timer_rec_t  wr_timer,
  input  cpts_pkg::slot_flags_t wr_flags,
  output cpts_pkg::frame_rec_t  rd_frame,
  output cpts_pkg::timer_rec_t  rd_timer,
  output cpts_pkg::slot_flags_t rd_flags
);
  import cpts_pkg::*;

  frame_rec_t  frame_mem [SLOTS];
  timer_rec_t  timer_mem [SLOTS];
  slot_flags_t flags_r   [SLOTS];

  frame_rec_t  rd_frame_r;
  timer_rec_t  rd_timer_r;
  slot_flags_t rd_flags_r;

  always_ff @(posedge clk) begin
    if (ctl.fr_we) begin
      frame_mem[ctl.wr_slot] <= wr_frame;
    end
    rd_frame_r <= frame_mem[ctl.rd_slot];
  end

  always_ff @(posedge clk) begin
    if (ctl.tm_we) begin
      timer_mem[ctl.wr_slot] <= wr_timer;
    end
    rd_timer_r <= timer_mem[ctl.rd_slot];
  end

  // Flags reset to zero so that unwritten slots never fire on a timer or key scan.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        flags_r[i] <= '0;
      end
    end else if (ctl.fr_we) begin
      flags_r[ctl.wr_slot] <= wr_flags;
    end
  end

  always_ff @(posedge clk) begin
    rd_flags_r <= flags_r[ctl.rd_slot];
  end

  assign rd_frame = rd_frame_r;
  assign rd_timer = rd_timer_r;
  assign rd_flags = rd_flags_r;

endmodule

### hdl/can_periodic_tx_scheduler.sv
// Top level of the CAN periodic transmit scheduler: sequencer, result buffer and config.
//
//   Channel   Handshake                  Beat contents
//   -------   ------------------------   ------------------------------------------
//   in_       start / busy               func, slot, frame fields, timer, key
//   out_      out_valid (strobe only)    tx_slot .. tx_cause, last
//   cfg_      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// A write item updates the slot table at the edge that accepts it and leaves busy low.
// A tick, key press or send scans a slot range at one slot per cycle through the
// registered reads of the slot memories.
// Reset (rst_n low, synchronous) clears the sequencer, the config registers and the
// slot flags; the slot memories themselves need no clearing pass.
// The receiver cannot stall: every result is shown for exactly one cycle.
module can_periodic_tx_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  // Input command channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [3:0]  in_slot,
  input  logic [28:0] in_frame_id,
  input  logic        in_ext_flag,
  input  logic        in_rtr_flag,
  input  logic [3:0]  in_data_len,
  input  logic [3:0]  in_bus_channel,
  input  logic [63:0] in_payload,
  input  logic        in_timer_on,
  input  logic [15:0] in_period_ticks,
  input  logic        in_key_on,
  input  logic [7:0]  in_key_code,
  // Result channel.
  output logic        out_valid,
  output logic [3:0]  out_tx_slot,
  output logic [28:0] out_tx_id,
  output logic        out_tx_ext,
  output logic        out_tx_rtr,
  output logic [3:0]  out_tx_len,
  output logic [3:0]  out_tx_channel,
  output logic [63:0] out_tx_data,
  output logic [31:0] out_tx_client,
  output logic [1:0]  out_tx_cause,
  output logic        out_last,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import cpts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [3:0]  chan;
    logic [63:0] data;
    logic [1:0]  cause;
  } result_t;

  // Configuration registers.
  logic        bus_r;
  logic [4:0]  cnt_r;
  logic [31:0] client_r;

  // Sequencer.
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  end_r, end_nxt;
  logic [1:0]        cause_r, cause_nxt;
  logic [7:0]        key_r, key_nxt;
  logic [RES_W-1:0]  n_r, n_nxt;

  // Evaluation stage, in the cycle after the read issue.
  logic              rd_vld_r, rd_vld_nxt;
  logic [SLOT_W-1:0] rd_slot_r, rd_slot_nxt;

  // One-deep holding buffer: a result leaves only once it is known whether it is the last.
  logic    pend_vld_r, pend_vld_nxt;
  result_t pend_r, pend_nxt;

  // Output registers.
  logic    out_valid_r, out_valid_nxt;
  logic    out_last_r, out_last_nxt;
  result_t out_r, out_nxt;
  logic [31:0] out_client_r;

  // Slot store interface.
  mem_ctl_t    mem_ctl;
  frame_rec_t  wr_frame;
  timer_rec_t  wr_timer;
  slot_flags_t wr_flags;
  frame_rec_t  rd_frame;
  timer_rec_t  rd_timer;
  slot_flags_t rd_flags;

  logic             accept;
  logic             item_write;
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] in_slot_w;
  logic             tm_expire;
  logic [15:0]      cd_new;
  logic             upd_we;
  logic             hit;
  logic             emit;
  logic [3:0]       len_sat;
  logic [63:0]      data_masked;
  result_t          new_res;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign item_write = accept && (in_func == FUNC_WRITE);
  assign cfg_ready  = 1'b1;
  assign in_slot_w  = CNT_W'(in_slot);

  // Number of slots scanned: the programmed count, capped at the table size.
  assign lim = (cnt_r < CNT_W'(SLOTS)) ? cnt_r : CNT_W'(SLOTS);

  // Timer update of the slot under evaluation: expire at one or zero, then reload.
  assign tm_expire = (rd_timer.cdown < 16'd2);
  assign cd_new    = tm_expire ? rd_timer.period : (rd_timer.cdown - 16'd1);
  assign upd_we    = rd_vld_r && (cause_r == CAUSE_TIMER) && rd_flags.timer_en;

  always_comb begin
    case (cause_r)
      CAUSE_TIMER: hit = rd_flags.timer_en && tm_expire;
      CAUSE_KEY:   hit = rd_flags.key_en && (rd_frame.key == key_r);
      CAUSE_SEND:  hit = 1'b1;
      default:     hit = 1'b0;
    endcase
  end

  assign emit = rd_vld_r && hit && (n_r < RES_W'(MAX_RES));

  // Length saturates at eight bytes; bytes at and above the length read as zero.
  assign len_sat = (rd_frame.len > 4'd8) ? 4'd8 : rd_frame.len;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      data_masked[8*i +: 8] = (4'(i) < len_sat) ? rd_frame.data[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    new_res.slot  = rd_slot_r;
    new_res.id    = rd_frame.id;
    new_res.ext   = rd_flags.ext;
    new_res.rtr   = rd_flags.rtr;
    new_res.len   = len_sat;
    new_res.chan  = rd_frame.chan;
    new_res.data  = data_masked;
    new_res.cause = cause_r;
  end

  // Slot store control. A write item and a timer update never coincide, since
  // write items are taken only while the sequencer is idle. Each slot is read and
  // written back once per scan, so a read never meets a pending write to its entry.
  always_comb begin
    mem_ctl.fr_we   = item_write && (in_slot_w < CNT_W'(SLOTS));
    mem_ctl.tm_we   = mem_ctl.fr_we || upd_we;
    mem_ctl.wr_slot = mem_ctl.fr_we ? in_slot : rd_slot_r;
    mem_ctl.rd_slot = ptr_r[SLOT_W-1:0];

    wr_frame.id   = in_frame_id;
    wr_frame.len  = in_data_len;
    wr_frame.chan = in_bus_channel;
    wr_frame.data = in_payload;
    wr_frame.key  = in_key_code;

    wr_flags.ext      = in_ext_flag;
    wr_flags.rtr      = in_rtr_flag;
    wr_flags.timer_en = in_timer_on;
    wr_flags.key_en   = in_key_on;

    if (mem_ctl.fr_we) begin
      wr_timer.period = in_period_ticks;
      wr_timer.cdown  = in_period_ticks;
    end else begin
      wr_timer.period = rd_timer.period;
      wr_timer.cdown  = cd_new;
    end
  end

  cpts_slot_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .wr_frame (wr_frame),
    .wr_timer (wr_timer),
    .wr_flags (wr_flags),
    .rd_frame (rd_frame),
    .rd_timer (rd_timer),
    .rd_flags (rd_flags)
  );

  // Sequencer: set up the scan range on accept, issue one read per cycle, then
  // release the held result as the last beat of the item.
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    end_nxt       = end_r;
    cause_nxt     = cause_r;
    key_nxt       = key_r;
    n_nxt         = n_r;
    rd_vld_nxt    = 1'b0;
    rd_slot_nxt   = rd_slot_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_last_nxt  = out_last_r;
    out_nxt       = out_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_func != FUNC_WRITE)) begin
          state_nxt = ST_SCAN;
          n_nxt     = '0;
          key_nxt   = in_key_code;
          ptr_nxt   = '0;
          end_nxt   = '0;
          case (in_func)
            FUNC_TICK: begin
              cause_nxt = CAUSE_TIMER;
              end_nxt   = bus_r ? lim : '0;
            end
            FUNC_KEY: begin
              cause_nxt = CAUSE_KEY;
              end_nxt   = bus_r ? lim : '0;
            end
            FUNC_SEND: begin
              // A direct send ignores the bus state but respects the slot count.
              cause_nxt = CAUSE_SEND;
              if (in_slot_w < lim) begin
                ptr_nxt = in_slot_w;
                end_nxt = in_slot_w + CNT_W'(1);
              end
            end
            default: begin
              cause_nxt = CAUSE_SEND;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ptr_r < end_r) begin
          rd_vld_nxt  = 1'b1;
          rd_slot_nxt = ptr_r[SLOT_W-1:0];
          ptr_nxt     = ptr_r + CNT_W'(1);
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          out_nxt       = pend_r;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A new hit pushes the held result out as a non-final beat.
    if (emit) begin
      n_nxt        = n_r + RES_W'(1);
      pend_vld_nxt = 1'b1;
      pend_nxt     = new_res;
      if (pend_vld_r) begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b0;
        out_nxt       = pend_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ptr_r       <= '0;
      end_r       <= '0;
      n_r         <= '0;
      rd_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bus_r       <= 1'b0;
      cnt_r       <= '0;
      client_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      end_r       <= end_nxt;
      n_r         <= n_nxt;
      rd_vld_r    <= rd_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BUS_CONNECTED: bus_r    <= cfg_data[0];
          CFG_SLOT_COUNT:    cnt_r    <= cfg_data[4:0];
          CFG_CLIENT_ID:     client_r <= cfg_data;
          default:           ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cause_r      <= cause_nxt;
    key_r        <= key_nxt;
    rd_slot_r    <= rd_slot_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
    out_last_r   <= out_last_nxt;
    out_client_r <= client_r;
  end

  assign out_valid      = out_valid_r;
  assign out_tx_slot    = out_r.slot;
  assign out_tx_id      = out_r.id;
  assign out_tx_ext     = out_r.ext;
  assign out_tx_rtr     = out_r.rtr;
  assign out_tx_len     = out_r.len;
  assign out_tx_channel = out_r.chan;
  assign out_tx_data    = out_r.data;
  assign out_tx_client  = out_client_r;
  assign out_tx_cause   = out_r.cause;
  assign out_last       = out_last_r;

  // The final beat of an item can only come from the flush step.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> $past(state_r == ST_FLUSH))
    else $error("final result beat not produced by the flush step");

  // An idle sequencer holds no result and has no read in flight.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!pend_vld_r && !rd_vld_r))
    else $error("result or read left over while idle");

  // The per-item result count never passes its limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_W'(MAX_RES))
    else $error("result count beyond limit");

endmodule

### sim/can_periodic_tx_scheduler_test.sv
// Self-checking testbench for the CAN periodic transmit scheduler: directed and random traffic.
`timescale 1ns / 1ps

module can_periodic_tx_scheduler_test;
  import cpts_pkg::*;

  // After the last frame we let a settle time pass before touching the registers,
  // because a tick that expires nothing keeps the block busy without producing a
  // beat on the result side.
  localparam int SCAN_SETTLE    = 24;
  // Cycles without any handshake on any channel before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 39;

  // One command beat as the sender sees it.
  typedef struct {
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [28:0] frame_id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [3:0]  chan;
    logic [63:0] payload;
    logic        timer_on;
    logic [15:0] period;
    logic        key_on;
    logic [7:0]  key;
  } cmd_t;

  // One transmitted frame as it should appear on the result ports.
  typedef struct {
    logic [3:0]  slot;
    logic [28:0] id;
    logic        ext;
    logic        rtr;
    logic [3:0]  len;
    logic [3:0]  chan;
    logic [63:0] data;
    logic [31:0] client;
    logic [1:0]  cause;
    logic        is_last;
  } tx_frame_t;

  // Every input starts at a known value; after that they only change at rising edges.
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        start          = 1'b0;
  logic [1:0]  in_func        = FUNC_TICK;
  logic [3:0]  in_slot        = '0;
  logic [28:0] in_frame_id    = '0;
  logic        in_ext_flag    = 1'b0;
  logic        in_rtr_flag    = 1'b0;
  logic [3:0]  in_data_len    = '0;
  logic [3:0]  in_bus_channel = '0;
  logic [63:0] in_payload     = '0;
  logic        in_timer_on    = 1'b0;
  logic [15:0] in_period_ticks = '0;
  logic        in_key_on      = 1'b0;
  logic [7:0]  in_key_code    = '0;
  logic        cfg_valid      = 1'b0;
  logic [1:0]  cfg_index      = CFG_BUS_CONNECTED;
  logic [31:0] cfg_data       = '0;

  logic        busy;
  logic        out_valid;
  logic [3:0]  out_tx_slot;
  logic [28:0] out_tx_id;
  logic        out_tx_ext;
  logic        out_tx_rtr;
  logic [3:0]  out_tx_len;
  logic [3:0]  out_tx_channel;
  logic [63:0] out_tx_data;
  logic [31:0] out_tx_client;
  logic [1:0]  out_tx_cause;
  logic        out_last;
  logic        cfg_ready;

  can_periodic_tx_scheduler u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_func        (in_func),
    .in_slot        (in_slot),
    .in_frame_id    (in_frame_id),
    .in_ext_flag    (in_ext_flag),
    .in_rtr_flag    (in_rtr_flag),
    .in_data_len    (in_data_len),
    .in_bus_channel (in_bus_channel),
    .in_payload     (in_payload),
    .in_timer_on    (in_timer_on),
    .in_period_ticks(in_period_ticks),
    .in_key_on      (in_key_on),
    .in_key_code    (in_key_code),
    .out_valid      (out_valid),
    .out_tx_slot    (out_tx_slot),
    .out_tx_id      (out_tx_id),
    .out_tx_ext     (out_tx_ext),
    .out_tx_rtr     (out_tx_rtr),
    .out_tx_len     (out_tx_len),
    .out_tx_channel (out_tx_channel),
    .out_tx_data    (out_tx_data),
    .out_tx_client  (out_tx_client),
    .out_tx_cause   (out_tx_cause),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Our own copy of the scheduler: registers and the slot table.
  logic        bus_on;
  logic [4:0]  slots_used;
  logic [31:0] client;
  logic [28:0] tbl_id        [SLOTS];
  slot_flags_t tbl_flags     [SLOTS];
  logic [3:0]  tbl_len       [SLOTS];
  logic [3:0]  tbl_chan      [SLOTS];
  logic [63:0] tbl_data      [SLOTS];
  logic [15:0] tbl_period    [SLOTS];
  logic [15:0] tbl_countdown [SLOTS];
  logic [7:0]  tbl_key       [SLOTS];
  bit          tbl_written   [SLOTS];

  // Frames that the block owes us, oldest first.
  tx_frame_t pending_frames[$];

  int errors = 0;
  int frames_checked = 0;
  int cmd_count [4] = '{default: 0};
  int cause_count [4] = '{default: 0};
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // The scan covers slot_count slots, but never more than the table holds.
  function automatic int scan_limit();
    return (slots_used < SLOTS) ? int'(slots_used) : SLOTS;
  endfunction

  // Builds the frame a slot produces. Lengths above eight are clipped to eight and
  // the data bytes past the length read as zero.
  function automatic tx_frame_t frame_of(input int s, input logic [1:0] cause);
    tx_frame_t   f;
    logic [3:0]  len;
    logic [63:0] mask;
    len  = (tbl_len[s] > 4'd8) ? 4'd8 : tbl_len[s];
    mask = (len >= 4'd8) ? '1 : ((64'd1 << (len * 8)) - 64'd1);
    f.slot    = 4'(s);
    f.id      = tbl_id[s];
    f.ext     = tbl_flags[s].ext;
    f.rtr     = tbl_flags[s].rtr;
    f.len     = len;
    f.chan    = tbl_chan[s];
    f.data    = tbl_data[s] & mask;
    f.client  = client;
    f.cause   = cause;
    f.is_last = 1'b0;
    return f;
  endfunction

  // Applies one accepted command to our slot table and queues the frames it causes,
  // in ascending slot order, with the last flag on the final one.
  task automatic predict_transmissions(input cmd_t c);
    tx_frame_t burst[$];
    int        lim;
    lim = scan_limit();
    case (c.func)
      FUNC_WRITE: begin
        // A write reloads the countdown from the new period.
        tbl_id[c.slot]            = c.frame_id;
        tbl_flags[c.slot].ext     = c.ext;
        tbl_flags[c.slot].rtr     = c.rtr;
        tbl_flags[c.slot].timer_en = c.timer_on;
        tbl_flags[c.slot].key_en  = c.key_on;
        tbl_len[c.slot]           = c.len;
        tbl_chan[c.slot]          = c.chan;
        tbl_data[c.slot]          = c.payload;
        tbl_period[c.slot]        = c.period;
        tbl_countdown[c.slot]     = c.period;
        tbl_key[c.slot]           = c.key;
        tbl_written[c.slot]       = 1'b1;
      end
      FUNC_SEND: begin
        // Direct sends ignore the bus state but not the scan limit.
        if (int'(c.slot) < lim) burst.push_back(frame_of(int'(c.slot), CAUSE_SEND));
      end
      FUNC_KEY: begin
        if (bus_on) begin
          for (int s = 0; s < lim; s++) begin
            if (tbl_flags[s].key_en && tbl_key[s] == c.key && burst.size() < MAX_RES)
              burst.push_back(frame_of(s, CAUSE_KEY));
          end
        end
      end
      default: begin
        // Tick: a countdown of zero or one in the scan range expires, transmits and
        // reloads; the other enabled ones there step down by one. Nothing moves while the bus is down.
        if (bus_on) begin
          for (int s = 0; s < lim; s++) begin
            if (!tbl_flags[s].timer_en) continue;
            if (tbl_countdown[s] <= 16'd1) begin
              if (burst.size() < MAX_RES) burst.push_back(frame_of(s, CAUSE_TIMER));
              tbl_countdown[s] = tbl_period[s];
            end else begin
              tbl_countdown[s] = tbl_countdown[s] - 16'd1;
            end
          end
        end
      end
    endcase
    if (burst.size() > 0) burst[burst.size() - 1].is_last = 1'b1;
    foreach (burst[i]) pending_frames.push_back(burst[i]);
  endtask

  // Result monitor. Each beat is on the ports for exactly one cycle and is taken at
  // the edge that ends it, so the ports are sampled right at the rising edge.
  always @(posedge clk) begin : check_frames
    tx_frame_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("frame from slot %0d with nothing expected", out_tx_slot));
      end else begin
        want = pending_frames.pop_front();
        check_field("tx_slot", 64'(out_tx_slot), 64'(want.slot));
        check_field("tx_id", 64'(out_tx_id), 64'(want.id));
        check_field("tx_ext", 64'(out_tx_ext), 64'(want.ext));
        check_field("tx_rtr", 64'(out_tx_rtr), 64'(want.rtr));
        check_field("tx_len", 64'(out_tx_len), 64'(want.len));
        check_field("tx_channel", 64'(out_tx_channel), 64'(want.chan));
        check_field("tx_data", out_tx_data, want.data);
        check_field("tx_client", 64'(out_tx_client), 64'(want.client));
        check_field("tx_cause", 64'(out_tx_cause), 64'(want.cause));
        check_field("last", 64'(out_last), 64'(want.is_last));
        frames_checked++;
        cause_count[want.cause]++;
      end
    end
  end

  // Watchdog: any accepted beat on any channel restarts the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1 || (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d frames still owed",
               quiet_cycles, pending_frames.size());
      $display("status: fail");
      $finish;
    end
  end

  // Sends one command beat. The sender first idles for a random number of cycles,
  // unless the current phase runs back to back; start then stays high until an edge
  // sees busy low. The task returns at the accepting edge with start still high, so a
  // following command with no gap keeps it high without a glitch.
  task automatic issue_command(input cmd_t c);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_func         <= c.func;
    in_slot         <= c.slot;
    in_frame_id     <= c.frame_id;
    in_ext_flag     <= c.ext;
    in_rtr_flag     <= c.rtr;
    in_data_len     <= c.len;
    in_bus_channel  <= c.chan;
    in_payload      <= c.payload;
    in_timer_on     <= c.timer_on;
    in_period_ticks <= c.period;
    in_key_on       <= c.key_on;
    in_key_code     <= c.key;
    do @(posedge clk); while (busy !== 1'b0);
    predict_transmissions(c);
    cmd_count[c.func]++;
  endtask

  // Stops sending and waits until every owed frame has arrived and the block is no
  // longer busy, then lets settle cycles pass for a scan that produced nothing.
  task automatic drain_frames(input int settle);
    start <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy !== 1'b0);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all three registers back to back; valid stays high across the beats and
  // drops after the last one. Only called while the block is idle.
  task automatic configure(input logic bus, input logic [4:0] count,
                           input logic [31:0] id);
    logic [1:0]  idx [3];
    logic [31:0] val [3];
    idx = '{CFG_BUS_CONNECTED, CFG_SLOT_COUNT, CFG_CLIENT_ID};
    val = '{{31'd0, bus}, {27'd0, count}, id};
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= val[r];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      case (idx[r])
        CFG_BUS_CONNECTED: bus_on     = val[r][0];
        CFG_SLOT_COUNT:    slots_used = val[r][4:0];
        default:           client     = val[r];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // A command with every field random; callers then pin what matters.
  function automatic cmd_t noise_cmd();
    cmd_t c;
    c.func     = 2'($urandom);
    c.slot     = 4'($urandom);
    c.frame_id = 29'($urandom);
    c.ext      = 1'($urandom);
    c.rtr      = 1'($urandom);
    c.len      = 4'($urandom);
    c.chan     = 4'($urandom);
    c.payload  = {$urandom, $urandom};
    c.timer_on = 1'($urandom);
    c.period   = 16'($urandom);
    c.key_on   = 1'($urandom);
    c.key      = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_t op_cmd(input logic [1:0] func, input logic [3:0] slot,
                                  input logic [7:0] key);
    cmd_t c;
    c      = noise_cmd();
    c.func = func;
    c.slot = slot;
    c.key  = key;
    return c;
  endfunction

  function automatic cmd_t write_cmd(input logic [3:0] slot, input logic [28:0] id,
                                     input logic ext, input logic rtr,
                                     input logic [3:0] len, input logic [3:0] chan,
                                     input logic [63:0] data, input logic timer_on,
                                     input logic [15:0] period, input logic key_on,
                                     input logic [7:0] key);
    cmd_t c;
    c.func = FUNC_WRITE;
    c.slot = slot;
    c.frame_id = id;
    c.ext = ext;
    c.rtr = rtr;
    c.len = len;
    c.chan = chan;
    c.payload = data;
    c.timer_on = timer_on;
    c.period = period;
    c.key_on = key_on;
    c.key = key;
    return c;
  endfunction

  // Key codes come mostly from a small pool so that key presses find matches.
  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h5A;
      3:       return 8'hA5;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random command mix. Writes use short periods most of the time so that timers
  // actually expire within a phase. A send to a slot inside the scan range that was
  // never loaded would read undefined contents, so it becomes a write of that slot.
  function automatic cmd_t random_cmd();
    cmd_t c;
    int   roll;
    c    = noise_cmd();
    roll = $urandom_range(0, 99);
    if (roll < 28) c.func = FUNC_WRITE;
    else if (roll < 58) c.func = FUNC_TICK;
    else if (roll < 78) begin
      c.func = FUNC_KEY;
      c.key  = pick_key();
    end else c.func = FUNC_SEND;
    if (c.func == FUNC_SEND && !tbl_written[c.slot] && int'(c.slot) < scan_limit())
      c.func = FUNC_WRITE;
    if (c.func == FUNC_WRITE) begin
      c.key = pick_key();
      c.len = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                           : 4'($urandom_range(0, 8));
      roll = $urandom_range(0, 99);
      if (roll < 60) c.period = 16'($urandom_range(0, 4));
      else if (roll < 85) c.period = 16'($urandom_range(5, 20));
    end
    return c;
  endfunction

  // Loads slots with extreme contents and sends them directly: all-ones identifier
  // with both flags, a length above eight, a zero length, a short length.
  task automatic test_write_and_send();
    issue_command(write_cmd(4'd0, 29'h1FFF_FFFF, 1'b1, 1'b1, 4'd15, 4'hF,
                            64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 16'hFFFF, 1'b1, 8'hFF));
    issue_command(write_cmd(4'd15, 29'h0, 1'b0, 1'b0, 4'd0, 4'h0,
                            64'h0123_4567_89AB_CDEF, 1'b1, 16'd1, 1'b1, 8'h00));
    issue_command(write_cmd(4'd3, 29'h0000_0123, 1'b0, 1'b1, 4'd3, 4'h5,
                            64'hA5A5_5A5A_F00F_0FF0, 1'b0, 16'd0, 1'b0, 8'hFF));
    issue_command(op_cmd(FUNC_SEND, 4'd0, 8'h00));
    issue_command(op_cmd(FUNC_SEND, 4'd15, 8'h00));
    issue_command(op_cmd(FUNC_SEND, 4'd3, 8'h00));
  endtask

  // Key presses: one match, one match on another slot, and a code nobody uses.
  // Slot 3 shares the code of slot 0 but has its key trigger off.
  task automatic test_key_press();
    issue_command(op_cmd(FUNC_KEY, 4'd0, 8'hFF));
    issue_command(op_cmd(FUNC_KEY, 4'd0, 8'h00));
    issue_command(op_cmd(FUNC_KEY, 4'd0, 8'h5A));
  endtask

  // Periods of zero, one and two, so both expiry conditions and plain decrements
  // show up; several slots expire on the same tick.
  task automatic test_timer_expiry();
    issue_command(write_cmd(4'd5, 29'h0ABC_DEF0, 1'b1, 1'b0, 4'd8, 4'h2,
                            64'h1122_3344_5566_7788, 1'b1, 16'd0, 1'b0, 8'h11));
    issue_command(write_cmd(4'd7, 29'h0000_07FF, 1'b0, 1'b0, 4'd1, 4'h9,
                            64'h8877_6655_4433_2211, 1'b1, 16'd2, 1'b0, 8'h22));
    repeat (3) issue_command(op_cmd(FUNC_TICK, 4'($urandom), 8'($urandom)));
  endtask

  // With the bus down, ticks and key presses must do nothing and the countdowns
  // must hold, while a direct send still goes out.
  task automatic test_bus_disconnected();
    drain_frames(SCAN_SETTLE);
    configure(1'b0, 5'd16, 32'hFFFF_FFFF);
    issue_command(op_cmd(FUNC_TICK, 4'd0, 8'h00));
    issue_command(op_cmd(FUNC_KEY, 4'd0, 8'hFF));
    issue_command(op_cmd(FUNC_SEND, 4'd0, 8'h00));
    drain_frames(SCAN_SETTLE);
    configure(1'b1, 5'd16, 32'h0000_0000);
  endtask

  // Scan range at zero, far above the table size, and at four slots, inside the table.
  task automatic test_scan_limit();
    drain_frames(SCAN_SETTLE);
    configure(1'b1, 5'd0, 32'h1234_5678);
    issue_command(op_cmd(FUNC_SEND, 4'd0, 8'h00));
    issue_command(op_cmd(FUNC_TICK, 4'd0, 8'h00));
    drain_frames(SCAN_SETTLE);
    configure(1'b1, 5'd31, 32'h8765_4321);
    issue_command(op_cmd(FUNC_TICK, 4'd0, 8'h00));
    drain_frames(SCAN_SETTLE);
    configure(1'b1, 5'd4, 32'hDEAD_BEEF);
    issue_command(op_cmd(FUNC_SEND, 4'd5, 8'h00));
    issue_command(op_cmd(FUNC_SEND, 4'd3, 8'h00));
    issue_command(op_cmd(FUNC_KEY, 4'd0, 8'hFF));
  endtask

  // Random traffic in phases, each under its own register setting. Two phases send
  // back to back; now and then the sender holds off until every frame is in.
  task automatic test_random_traffic();
    for (int p = 0; p < PHASES; p++) begin
      drain_frames(SCAN_SETTLE);
      case (p)
        0:       configure(1'b1, 5'd16, $urandom);
        1:       configure(1'b1, 5'd31, 32'hFFFF_FFFF);
        2:       configure(1'b0, 5'd16, $urandom);
        3:       configure(1'b1, 5'($urandom_range(1, 15)), $urandom);
        4:       configure(1'b1, 5'd0, 32'h0000_0000);
        default: configure(1'b1, 5'($urandom_range(8, 16)), $urandom);
      endcase
      no_gaps = (p == 3 || p == 6);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 24) == 0) drain_frames(0);
        issue_command(random_cmd());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    bus_on     = 1'b0;
    slots_used = '0;
    client     = '0;
    foreach (tbl_flags[s]) begin
      tbl_flags[s]     = '0;
      tbl_written[s]   = 1'b0;
      tbl_countdown[s] = '0;
    end

    // Synchronous reset, held low from the start and released at a rising edge.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    configure(1'b1, 5'd16, 32'hFFFF_FFFF);
    test_write_and_send();
    test_key_press();
    test_timer_expiry();
    test_bus_disconnected();
    test_scan_limit();
    test_random_traffic();
    drain_frames(SCAN_SETTLE);

    if (pending_frames.size() != 0)
      report_mismatch($sformatf("%0d frames never arrived", pending_frames.size()));

    $display("run covered %0d commands: %0d writes, %0d ticks, %0d key presses, %0d sends",
             cmd_count[FUNC_WRITE] + cmd_count[FUNC_TICK] + cmd_count[FUNC_KEY] +
             cmd_count[FUNC_SEND], cmd_count[FUNC_WRITE], cmd_count[FUNC_TICK],
             cmd_count[FUNC_KEY], cmd_count[FUNC_SEND]);
    $display("%0d frames compared (%0d timer, %0d key, %0d direct), %0d mismatches",
             frames_checked, cause_count[CAUSE_TIMER], cause_count[CAUSE_KEY],
             cause_count[CAUSE_SEND], errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/cpts_pkg.sv
hdl/cpts_slot_store.sv
hdl/can_periodic_tx_scheduler.sv
sim/can_periodic_tx_scheduler_test.sv
